/* sv/cdeq_pkg.sv */
package cdeq_pkg;

	// Queue capacity, the widths that follow from it, and the fixed field widths.
	localparam int unsigned DEPTH  = 8;
	localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned WORD_W = 32;
	localparam int unsigned OCC_W  = 4;
	localparam int unsigned REQ_W  = 3;
	localparam int unsigned STAT_W = 2;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_STATUS     = 3'd4
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} stat_t;

	// Per-cell control: take the lower neighbor, take the upper neighbor,
	// or load the pushed word.
	typedef struct packed {
		logic shift_up;
		logic shift_down;
		logic load;
	} cell_ctrl_t;

endpackage

/* sv/cdeq_cell.sv */
// One storage cell of the queue row. Cell 0 holds the front word.
module cdeq_cell (
	input  logic                 clk,
	input  cdeq_pkg::cell_ctrl_t ctrl,
	input  cdeq_pkg::word_t      left_word,
	input  cdeq_pkg::word_t      right_word,
	input  cdeq_pkg::word_t      data_word,
	output cdeq_pkg::word_t      word,
	output cdeq_pkg::word_t      word_nxt
);

	cdeq_pkg::word_t word_q;

	always_comb begin
		if (ctrl.shift_up) begin
			word_nxt = left_word;
		end else if (ctrl.shift_down) begin
			word_nxt = right_word;
		end else if (ctrl.load) begin
			word_nxt = data_word;
		end else begin
			word_nxt = word_q;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

	assign word = word_q;

endmodule

/* sv/circular_double_ended_queue_core.sv */
// Channel   Direction  Handshake              Payload
// request   in         req_valid / req_stall  req_type, data_in
// result    out        rsp_valid / rsp_stall  status, front_value, back_value,
//                                              occupancy, is_empty
//
// The row of cells updates at the edge that accepts a request, and its result
// is loaded into the output register at that same edge. A new request is
// taken every cycle unless a held result is stalled.
// Reset clears the count and the output valid; cell contents are not reset.
// While the result register holds a stalled result, req_stall is raised.
module circular_double_ended_queue_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] data_in,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value,
	output logic [3:0]         occupancy,
	output logic               is_empty
);

	localparam int unsigned DEPTH = cdeq_pkg::DEPTH;
	localparam int unsigned IDX_W = cdeq_pkg::IDX_W;
	localparam int unsigned CNT_W = cdeq_pkg::CNT_W;

	// The words are kept in order in a row of cells: cell 0 is the front and
	// cell count-1 is the back. A push at the front shifts the row up, a pop
	// at the front shifts it down, a push at the back loads the cell at the
	// current count, and a pop at the back only lowers the count. The
	// circular head and tail indices of a ring buffer are thus implicit.

	logic                 req_acc;
	logic                 rsp_take;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     cnt_nxt;
	logic                 full;
	logic                 empty;
	logic                 shift_up;
	logic                 shift_down;
	logic                 tail_load;
	cdeq_pkg::stat_t      st_nxt;
	cdeq_pkg::word_t      words     [DEPTH];
	cdeq_pkg::word_t      words_nxt [DEPTH];
	cdeq_pkg::word_t      front_nxt;
	cdeq_pkg::word_t      back_nxt;
	logic [IDX_W-1:0]     back_idx;

	// Result register.
	logic                 rsp_valid_q;
	cdeq_pkg::stat_t      status_q;
	cdeq_pkg::word_t      front_q;
	cdeq_pkg::word_t      back_q;
	logic [CNT_W-1:0]     occ_q;
	logic                 empty_q;

	assign rsp_take  = rsp_valid_q && !rsp_stall;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_acc   = req_valid && !req_stall;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Decode the request into row moves and the new count.
	always_comb begin
		st_nxt     = cdeq_pkg::ST_DONE;
		cnt_nxt    = count_q;
		shift_up   = 1'b0;
		shift_down = 1'b0;
		tail_load  = 1'b0;
		case (cdeq_pkg::req_t'(req_type))
			cdeq_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					st_nxt = cdeq_pkg::ST_OVERFLOW;
				end else begin
					tail_load = 1'b1;
					cnt_nxt   = count_q + CNT_W'(1);
				end
			end
			cdeq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					st_nxt = cdeq_pkg::ST_OVERFLOW;
				end else begin
					shift_up = 1'b1;
					cnt_nxt  = count_q + CNT_W'(1);
				end
			end
			cdeq_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					st_nxt = cdeq_pkg::ST_UNDERFLOW;
				end else begin
					shift_down = 1'b1;
					cnt_nxt    = count_q - CNT_W'(1);
				end
			end
			cdeq_pkg::REQ_POP_BACK: begin
				if (empty) begin
					st_nxt = cdeq_pkg::ST_UNDERFLOW;
				end else begin
					cnt_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
				// Status request and unused codes leave the queue alone.
			end
		endcase
	end

	// The row of cells. Cell 0 takes the pushed word on a front push; the
	// top cell has no upper neighbor and sees its own word.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cdeq_pkg::cell_ctrl_t ctrl;
		cdeq_pkg::word_t      left_w;
		cdeq_pkg::word_t      right_w;

		assign ctrl = '{
			shift_up:   req_acc && shift_up,
			shift_down: req_acc && shift_down,
			load:       req_acc && tail_load && (count_q == CNT_W'(i))
		};

		if (i == 0) begin : g_first
			assign left_w = data_in;
		end else begin : g_mid
			assign left_w = words[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = words[i];
		end else begin : g_up
			assign right_w = words[i+1];
		end

		cdeq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_word  (left_w),
			.right_word (right_w),
			.data_word  (data_in),
			.word       (words[i]),
			.word_nxt   (words_nxt[i])
		);
	end

	// Front and back after the request; both read as all ones when empty.
	assign back_idx  = IDX_W'(cnt_nxt - CNT_W'(1));
	assign front_nxt = (cnt_nxt == '0) ? '1 : words_nxt[0];
	assign back_nxt  = (cnt_nxt == '0) ? '1 : words_nxt[back_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				count_q     <= cnt_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			status_q <= st_nxt;
			front_q  <= front_nxt;
			back_q   <= back_nxt;
			occ_q    <= cnt_nxt;
			empty_q  <= (cnt_nxt == '0);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign front_value = front_q;
	assign back_value  = back_q;
	assign occupancy   = 4'(occ_q);
	assign is_empty    = empty_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stored count exceeds capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && !full && (req_type == cdeq_pkg::REQ_PUSH_BACK ||
		req_type == cdeq_pkg::REQ_PUSH_FRONT)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted push did not raise the count");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == cdeq_pkg::ST_OVERFLOW |-> occ_q == CNT_W'(DEPTH))
		else $error("overflow reported while not full");

	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && empty_q |-> front_q == '1 && back_q == '1 && occ_q == '0)
		else $error("empty result carries words");
`endif

endmodule

/* tb/deque_result_checker.sv */
`timescale 1ns / 1ps

module deque_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] data_in,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic [1:0]         status,
	input  logic signed [31:0] front_value,
	input  logic signed [31:0] back_value,
	input  logic [3:0]         occupancy,
	input  logic               is_empty,
	output int                 outstanding,
	output int                 mismatches
);

	localparam int unsigned DEPTH = cdeq_pkg::DEPTH;
	localparam int unsigned IDX_W = cdeq_pkg::IDX_W;
	localparam int unsigned OCC_W = cdeq_pkg::OCC_W;
	localparam int unsigned REQ_W = cdeq_pkg::REQ_W;

	typedef struct packed {
		cdeq_pkg::stat_t  st;
		cdeq_pkg::word_t  front;
		cdeq_pkg::word_t  back;
		logic [OCC_W-1:0] occ;
		logic             empty;
	} deque_view_t;

	cdeq_pkg::word_t  slot_mem [DEPTH];
	logic [IDX_W-1:0] head_pos;
	logic [IDX_W-1:0] tail_pos;
	int unsigned      word_cnt;
	deque_view_t      predicted_results [$];
	deque_view_t      due;

	// Applies one request to the local copy of the queue and returns the view after it.
	function automatic deque_view_t apply_request(logic [REQ_W-1:0] code,
			cdeq_pkg::word_t word);
		deque_view_t v;
		v.st = cdeq_pkg::ST_DONE;
		case (code)
			cdeq_pkg::REQ_PUSH_BACK, cdeq_pkg::REQ_PUSH_FRONT: begin
				if (word_cnt >= DEPTH) begin
					v.st = cdeq_pkg::ST_OVERFLOW;
				end else if (word_cnt == 0) begin
					head_pos    = '0;
					tail_pos    = '0;
					slot_mem[0] = word;
					word_cnt    = 1;
				end else if (code == cdeq_pkg::REQ_PUSH_BACK) begin
					tail_pos           = IDX_W'((32'(tail_pos) + 1) % DEPTH);
					slot_mem[tail_pos] = word;
					word_cnt++;
				end else begin
					head_pos           = IDX_W'((32'(head_pos) + DEPTH - 1) % DEPTH);
					slot_mem[head_pos] = word;
					word_cnt++;
				end
			end
			cdeq_pkg::REQ_POP_FRONT, cdeq_pkg::REQ_POP_BACK: begin
				if (word_cnt == 0) begin
					v.st = cdeq_pkg::ST_UNDERFLOW;
				end else if (word_cnt == 1) begin
					head_pos = '0;
					tail_pos = '0;
					word_cnt = 0;
				end else begin
					if (code == cdeq_pkg::REQ_POP_FRONT)
						head_pos = IDX_W'((32'(head_pos) + 1) % DEPTH);
					else
						tail_pos = IDX_W'((32'(tail_pos) + DEPTH - 1) % DEPTH);
					word_cnt--;
				end
			end
			default: ;
		endcase
		v.front = (word_cnt == 0) ? '1 : slot_mem[head_pos];
		v.back  = (word_cnt == 0) ? '1 : slot_mem[tail_pos];
		v.occ   = word_cnt[OCC_W-1:0];
		v.empty = (word_cnt == 0);
		return v;
	endfunction

	// Prints one line for the mismatch and counts it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_pos    = '0;
			tail_pos    = '0;
			word_cnt    = 0;
			mismatches  = 0;
			predicted_results.delete();
			outstanding <= 0;
			foreach (slot_mem[i])
				slot_mem[i] = '0;
		end else begin
			// The result leaving at this edge belongs to an earlier request, so it is
			// matched before the request taken at the same edge is queued.
			if (rsp_valid && !rsp_stall) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("result with no request waiting", 32'(occupancy), '0);
				end else begin
					due = predicted_results[0];
					predicted_results.delete(0);
					if (status !== due.st)
						report_mismatch("status", 32'(status), 32'(due.st));
					if (front_value !== due.front)
						report_mismatch("front_value", front_value, due.front);
					if (back_value !== due.back)
						report_mismatch("back_value", back_value, due.back);
					if (occupancy !== due.occ)
						report_mismatch("occupancy", 32'(occupancy), 32'(due.occ));
					if (is_empty !== due.empty)
						report_mismatch("is_empty", 32'(is_empty), 32'(due.empty));
				end
			end
			if (req_valid && !req_stall)
				predicted_results.insert(predicted_results.size(),
					apply_request(req_type, data_in));
			outstanding <= predicted_results.size();
		end
	end

endmodule

/* tb/circular_double_ended_queue_core_test.sv */
`timescale 1ns / 1ps

module circular_double_ended_queue_core_test;

	// Number of random requests after the directed part.
	localparam int unsigned RANDOM_ITEMS = 1725;
	// Worst case per request is the random idle time on each side plus the
	// pipeline itself; this leaves a wide margin.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	// Cycles to keep watching for stray results once everything has arrived.
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned LAST_CODE    = (1 << cdeq_pkg::REQ_W) - 1;
	localparam int unsigned DEPTH        = cdeq_pkg::DEPTH;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [2:0]         req_type;
	logic signed [31:0] data_in;
	logic               rsp_valid;
	logic               rsp_stall;
	logic [1:0]         status;
	logic signed [31:0] front_value;
	logic signed [31:0] back_value;
	logic [3:0]         occupancy;
	logic               is_empty;

	int          outstanding;
	int          mismatches;
	int unsigned cycle_count = 0;
	// Upper bounds of the random idle time on each side; 0 means no idling.
	int unsigned req_gap_max  = 0;
	int unsigned resp_gap_max = 0;

	always #6 clk = ~clk;

	circular_double_ended_queue_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.data_in    (data_in),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.front_value(front_value),
		.back_value (back_value),
		.occupancy  (occupancy),
		.is_empty   (is_empty)
	);

	deque_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.data_in    (data_in),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.front_value(front_value),
		.back_value (back_value),
		.occupancy  (occupancy),
		.is_empty   (is_empty),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	// A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Picks a word, leaning on the extremes of the signed range now and then.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return '1;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	// Pushes make up push_pct percent; a small share are status or unused codes.
	function automatic logic [2:0] pick_code(int unsigned push_pct);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			return $urandom_range(0, 1) ? cdeq_pkg::REQ_PUSH_FRONT : cdeq_pkg::REQ_PUSH_BACK;
		else if (roll < 94)
			return $urandom_range(0, 1) ? cdeq_pkg::REQ_POP_FRONT : cdeq_pkg::REQ_POP_BACK;
		else
			return 3'($urandom_range(cdeq_pkg::REQ_STATUS, LAST_CODE));
	endfunction

	// Idle profile for one phase: none, light or heavy.
	function automatic int unsigned pick_gap_limit();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 2;
			default: return 16;
		endcase
	endfunction

	// Offers one request after a random gap and returns at the edge that takes it.
	// It always starts and ends on a rising edge, so valid gets one update per step.
	task automatic send_request(input logic [2:0] code, input logic [31:0] word);
		int unsigned gap;
		gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= code;
		data_in   <= word;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Holds off new requests until every result that is owed has come back.
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Result side: before each result it stalls for a random number of cycles,
	// then stays ready until a result is taken.
	initial begin : result_sink
		int unsigned hold;
		rsp_stall <= 1'b0;
		forever begin
			hold = (resp_gap_max == 0) ? 0 : $urandom_range(0, resp_gap_max);
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!(rsp_valid && !rsp_stall))
				@(posedge clk);
		end
	end

	initial begin : request_source
		int unsigned sent;
		int unsigned push_pct;
		int unsigned phase_len;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_type  <= cdeq_pkg::REQ_STATUS;
		data_in   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with light idling on both sides.
		req_gap_max  = 2;
		resp_gap_max = 2;
		// Status and pops on the empty queue; the pops must report underflow.
		send_request(cdeq_pkg::REQ_STATUS, pick_word());
		send_request(cdeq_pkg::REQ_POP_FRONT, pick_word());
		send_request(cdeq_pkg::REQ_POP_BACK, pick_word());
		// Codes past the status request behave as status only.
		for (int c = cdeq_pkg::REQ_STATUS + 1; c <= LAST_CODE; c++)
			send_request(3'(c), pick_word());
		// A push into the empty queue, then a push at the front that moves the
		// head back to the last slot while the tail stays at slot zero.
		send_request(cdeq_pkg::REQ_PUSH_BACK, 32'h7FFF_FFFF);
		send_request(cdeq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
		// Popping the front from the last slot must wrap the head to slot zero,
		// and popping the only word left empties the queue.
		send_request(cdeq_pkg::REQ_POP_FRONT, pick_word());
		send_request(cdeq_pkg::REQ_POP_FRONT, pick_word());
		// Fill up from empty with mixed ends, then push into the full queue.
		send_request(cdeq_pkg::REQ_PUSH_FRONT, '1);
		send_request(cdeq_pkg::REQ_PUSH_BACK, '0);
		for (int k = 0; k < DEPTH - 2; k++)
			send_request(k[0] ? cdeq_pkg::REQ_PUSH_FRONT : cdeq_pkg::REQ_PUSH_BACK, $urandom);
		send_request(cdeq_pkg::REQ_PUSH_BACK, 32'h5555_5555);
		send_request(cdeq_pkg::REQ_PUSH_FRONT, 32'hAAAA_AAAA);
		send_request(cdeq_pkg::REQ_STATUS, pick_word());
		send_request(cdeq_pkg::REQ_POP_BACK, pick_word());
		send_request(cdeq_pkg::REQ_POP_FRONT, pick_word());
		// Let the pipeline run dry once before the random part.
		drain_results();

		// Random part: each phase is drawn at random as filling, draining or a
		// balanced mix, so the queue keeps crossing between empty and full, with a
		// fresh idle profile on each side per phase.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0:       push_pct = 20;
				1:       push_pct = 50;
				default: push_pct = 80;
			endcase
			phase_len    = $urandom_range(16, 64);
			req_gap_max  = pick_gap_limit();
			resp_gap_max = pick_gap_limit();
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				send_request(pick_code(push_pct), pick_word());
				sent++;
			end
			if ($urandom_range(0, 4) == 0)
				drain_results();
		end

		// Wait for the last results, then watch a little longer for strays.
		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* circular_double_ended_queue_core.f */
sv/cdeq_pkg.sv
sv/cdeq_cell.sv
sv/circular_double_ended_queue_core.sv
tb/deque_result_checker.sv
tb/circular_double_ended_queue_core_test.sv
